// ----- sv/tafs_pkg.sv -----
// Shared types and constants for the triangle apex pipeline.
// Depends on nothing; every other file imports it.
package tafs_pkg;

  // Fixed port widths
  localparam int MM_BITS    = 14;
  localparam int STEP_BITS  = 24;
  localparam int CFG_BITS   = 16;

  // Millimetre to micrometre scale and the bits it adds
  localparam int STEP_SCALE = 1000;
  localparam int SCALE_BITS = 10;

  // Saturation limit of a step count
  localparam logic [STEP_BITS-1:0] STEPS_MAX = '1;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic invalid;
  } tafs_ctrl_t;

endpackage

// ----- sv/triangle_apex_from_sides.sv -----
// Top level of the triangle apex pipeline.
// Depends on tafs_pkg, tafs_front, tafs_hdiv, tafs_sqrt, tafs_steps.
//
// Usage:
//   Drive top_length, left_length and right_length with start high; the
//   transfer happens at a rising edge where start is high and busy is low.
//   busy is high only while rst is high, so a new triangle may enter on
//   every cycle.
//   Each triangle gives one result on apex_x_mm, apex_y_mm, apex_x_steps,
//   apex_y_steps and invalid, marked by done for exactly one cycle, in
//   order of entry. The receiver cannot stall the block.
//   The pipeline is four front stages, one stage per bit of the y^2 divider
//   (2*LENGTH_BITS + 2*FRAC_BITS), one per root bit of the square root
//   (LENGTH_BITS + FRAC_BITS), two rounding/scale stages, one per bit of
//   the step dividers (LENGTH_BITS + 11) and the result register.
//   Throughput is one triangle per cycle.
//   micrometres_per_step is written through cfg_write_en/cfg_write_data;
//   the user must write it only while no triangle is in flight, which the
//   block does not enforce. Reset empties the pipeline and clears the
//   step size to zero.
module triangle_apex_from_sides import tafs_pkg::*; #(
  parameter int LENGTH_BITS = 14,
  parameter int FRAC_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [13:0]           top_length,
  input  logic [13:0]           left_length,
  input  logic [13:0]           right_length,
  input  logic                  cfg_write_en,
  input  logic [CFG_BITS-1:0]   cfg_write_data,
  output logic                  done,
  output logic [MM_BITS-1:0]    apex_x_mm,
  output logic [MM_BITS-1:0]    apex_y_mm,
  output logic [STEP_BITS-1:0]  apex_x_steps,
  output logic [STEP_BITS-1:0]  apex_y_steps,
  output logic                  invalid
);

  localparam int L  = LENGTH_BITS;
  localparam int F  = FRAC_BITS;

  logic [CFG_BITS-1:0] micrometres_per_step;
  logic [L-1:0]        a, b, c;

  tafs_ctrl_t          front_ctrl, div_ctrl, sqrt_ctrl;
  logic [4*L+1:0]      p;
  logic [2*L+1:0]      d;
  logic [2*L:0]        dabs;
  logic [L:0]          a2;
  logic [2*L+2*F-1:0]  ysq;
  logic [L+F-1:0]      xfx_div, xfx, yfx;

  // Hold step size register
  always_ff @(posedge clk) begin
    if (rst) begin
      micrometres_per_step <= '0;
    end else if (cfg_write_en) begin
      micrometres_per_step <= cfg_write_data;
    end
  end

  assign busy = rst;

  // Keep the low LENGTH_BITS of each side
  assign a = L'({{L{1'b0}}, top_length});
  assign b = L'({{L{1'b0}}, left_length});
  assign c = L'({{L{1'b0}}, right_length});

  tafs_front #(.LENGTH_BITS(L)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .top_len   (a),
    .left_len  (b),
    .right_len (c),
    .ctrl_out  (front_ctrl),
    .p_out     (p),
    .d_out     (d),
    .dabs_out  (dabs),
    .a2_out    (a2)
  );

  tafs_hdiv #(.LENGTH_BITS(L), .FRAC_BITS(F)) u_hdiv (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (front_ctrl),
    .p_in     (p),
    .d_in     (d),
    .dabs_in  (dabs),
    .a2_in    (a2),
    .ctrl_out (div_ctrl),
    .ysq_out  (ysq),
    .xfx_out  (xfx_div)
  );

  tafs_sqrt #(.LENGTH_BITS(L), .FRAC_BITS(F)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (div_ctrl),
    .ysq_in   (ysq),
    .xfx_in   (xfx_div),
    .ctrl_out (sqrt_ctrl),
    .yfx_out  (yfx),
    .xfx_out  (xfx)
  );

  tafs_steps #(.LENGTH_BITS(L), .FRAC_BITS(F)) u_steps (
    .clk          (clk),
    .rst          (rst),
    .step_size    (micrometres_per_step),
    .ctrl_in      (sqrt_ctrl),
    .xfx_in       (xfx),
    .yfx_in       (yfx),
    .done         (done),
    .apex_x_mm    (apex_x_mm),
    .apex_y_mm    (apex_y_mm),
    .apex_x_steps (apex_x_steps),
    .apex_y_steps (apex_y_steps),
    .invalid      (invalid)
  );

endmodule

// ----- sv/tafs_front.sv -----
// Front end: squares, |D| and 16*Area^2 over four register stages.
// Depends on tafs_pkg.
module tafs_front import tafs_pkg::*; #(
  parameter int LENGTH_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [LENGTH_BITS-1:0]     top_len,
  input  logic [LENGTH_BITS-1:0]     left_len,
  input  logic [LENGTH_BITS-1:0]     right_len,
  output tafs_ctrl_t                 ctrl_out,
  output logic [4*LENGTH_BITS+1:0]   p_out,
  output logic [2*LENGTH_BITS+1:0]   d_out,
  output logic [2*LENGTH_BITS:0]     dabs_out,
  output logic [LENGTH_BITS:0]       a2_out
);

  localparam int L  = LENGTH_BITS;
  localparam int AW = 2 * L;
  localparam int PW = 4 * L + 2;

  tafs_ctrl_t ctrl1, ctrl2, ctrl3, ctrl_in;
  logic [L:0]    sum_bc, sum_ac, sum_ab;
  logic          bad;
  logic [AW-1:0] aa, bb, cc, ab;
  logic [L-1:0]  a1;
  logic [AW:0]   sab, ccx;
  logic [AW:0]   dabs2, tab2, dabs3;
  logic [AW+1:0] d2, d3;
  logic [L:0]    a2_2, a2_3;
  logic [PW-1:0] sq1, sq2;

  // Reject zero sides and broken triangle inequality
  always_comb begin
    sum_bc = (L+1)'(left_len) + (L+1)'(right_len);
    sum_ac = (L+1)'(top_len) + (L+1)'(right_len);
    sum_ab = (L+1)'(top_len) + (L+1)'(left_len);
    bad = (top_len == '0) || (left_len == '0) || (right_len == '0) ||
          (sum_bc < (L+1)'(top_len)) || (sum_ac < (L+1)'(left_len)) ||
          (sum_ab < (L+1)'(right_len));
    ctrl_in.valid   = in_valid;
    ctrl_in.invalid = bad;
    sab = (AW+1)'(aa) + (AW+1)'(bb);
    ccx = (AW+1)'(cc);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1    <= '0;
      ctrl2    <= '0;
      ctrl3    <= '0;
      ctrl_out <= '0;
    end else begin
      ctrl1    <= ctrl_in;
      ctrl2    <= ctrl1;
      ctrl3    <= ctrl2;
      ctrl_out <= ctrl3;
    end
  end

  // Stage 1: products of the sides
  always_ff @(posedge clk) begin
    aa <= AW'(top_len) * AW'(top_len);
    bb <= AW'(left_len) * AW'(left_len);
    cc <= AW'(right_len) * AW'(right_len);
    ab <= AW'(top_len) * AW'(left_len);
    a1 <= top_len;
  end

  // Stage 2: |a^2 + b^2 - c^2|, 2ab, 4a^2, 2a
  always_ff @(posedge clk) begin
    dabs2 <= (sab >= ccx) ? sab - ccx : ccx - sab;
    tab2  <= {ab, 1'b0};
    d2    <= {aa, 2'b00};
    a2_2  <= {a1, 1'b0};
  end

  // Stage 3: square both terms
  always_ff @(posedge clk) begin
    sq1   <= PW'(tab2) * PW'(tab2);
    sq2   <= PW'(dabs2) * PW'(dabs2);
    dabs3 <= dabs2;
    d3    <= d2;
    a2_3  <= a2_2;
  end

  // Stage 4: 16*Area^2
  always_ff @(posedge clk) begin
    p_out    <= sq1 - sq2;
    d_out    <= d3;
    dabs_out <= dabs3;
    a2_out   <= a2_3;
  end

endmodule

// ----- sv/tafs_hdiv.sv -----
// Pipelined restoring dividers for y^2 and x, one quotient bit per stage.
// Depends on tafs_pkg.
module tafs_hdiv import tafs_pkg::*; #(
  parameter int LENGTH_BITS = 14,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tafs_ctrl_t                            ctrl_in,
  input  logic [4*LENGTH_BITS+1:0]              p_in,
  input  logic [2*LENGTH_BITS+1:0]              d_in,
  input  logic [2*LENGTH_BITS:0]                dabs_in,
  input  logic [LENGTH_BITS:0]                  a2_in,
  output tafs_ctrl_t                            ctrl_out,
  output logic [2*LENGTH_BITS+2*FRAC_BITS-1:0]  ysq_out,
  output logic [LENGTH_BITS+FRAC_BITS-1:0]      xfx_out
);

  localparam int L  = LENGTH_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QW = 2 * L + 2 * F;
  localparam int QX = L + F;
  localparam int DW = 2 * L + 2;
  localparam int XW = L + 1;

  tafs_ctrl_t    ctl [QW+1];
  logic [DW-1:0] yr  [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] yn  [QW+1];
  logic [XW-1:0] xr  [QW+1];
  logic [XW-1:0] xd  [QW+1];
  logic [QX-1:0] xn  [QW+1];

  // Load partial remainders and the dividend bits still to shift in
  assign ctl[0] = ctrl_in;
  assign yr[0]  = p_in[4*L+1:2*L];
  assign yn[0]  = {p_in[2*L-1:0], {(2*F){1'b0}}};
  assign dv[0]  = d_in;
  assign xr[0]  = dabs_in[2*L:L];
  assign xn[0]  = {dabs_in[L-1:0], {F{1'b0}}};
  assign xd[0]  = a2_in;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] ye;
    logic        ygo;

    // One y^2 quotient bit
    always_comb begin
      ye  = {yr[k], yn[k][QW-1]};
      ygo = (ye >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else begin
        ctl[k+1] <= ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      yr[k+1] <= ygo ? DW'(ye - {1'b0, dv[k]}) : ye[DW-1:0];
      yn[k+1] <= {yn[k][QW-2:0], ygo};
      dv[k+1] <= dv[k];
      xd[k+1] <= xd[k];
    end

    if (k < QX) begin : g_x
      logic [XW:0] xe;
      logic        xgo;

      // One x quotient bit
      always_comb begin
        xe  = {xr[k], xn[k][QX-1]};
        xgo = (xe >= {1'b0, xd[k]});
      end

      always_ff @(posedge clk) begin
        xr[k+1] <= xgo ? XW'(xe - {1'b0, xd[k]}) : xe[XW-1:0];
        xn[k+1] <= {xn[k][QX-2:0], xgo};
      end
    end else begin : g_xhold
      // Hold the finished x quotient
      always_ff @(posedge clk) begin
        xr[k+1] <= xr[k];
        xn[k+1] <= xn[k];
      end
    end
  end

  assign ctrl_out = ctl[QW];
  assign ysq_out  = yn[QW];
  assign xfx_out  = xn[QW];

endmodule

// ----- sv/tafs_sqrt.sv -----
// Pipelined digit-by-digit square root of y^2, one root bit per stage.
// Depends on tafs_pkg.
module tafs_sqrt import tafs_pkg::*; #(
  parameter int LENGTH_BITS = 14,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tafs_ctrl_t                            ctrl_in,
  input  logic [2*LENGTH_BITS+2*FRAC_BITS-1:0]  ysq_in,
  input  logic [LENGTH_BITS+FRAC_BITS-1:0]      xfx_in,
  output tafs_ctrl_t                            ctrl_out,
  output logic [LENGTH_BITS+FRAC_BITS-1:0]      yfx_out,
  output logic [LENGTH_BITS+FRAC_BITS-1:0]      xfx_out
);

  localparam int QW = 2 * (LENGTH_BITS + FRAC_BITS);
  localparam int RB = LENGTH_BITS + FRAC_BITS;
  localparam int RW = RB + 2;

  tafs_ctrl_t    ctl  [RB+1];
  logic [RW-1:0] rem  [RB+1];
  logic [RB-1:0] root [RB+1];
  logic [QW-1:0] rn   [RB+1];
  logic [RB-1:0] xq   [RB+1];

  assign ctl[0]  = ctrl_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rn[0]   = ysq_in;
  assign xq[0]   = xfx_in;

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RW-1:0] ext, trial;
    logic          go;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      ext   = {rem[k][RW-3:0], rn[k][QW-1:QW-2]};
      trial = {root[k], 2'b01};
      go    = (ext >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else begin
        ctl[k+1] <= ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= go ? ext - trial : ext;
      root[k+1] <= {root[k][RB-2:0], go};
      rn[k+1]   <= {rn[k][QW-3:0], 2'b00};
      xq[k+1]   <= xq[k];
    end
  end

  assign ctrl_out = ctl[RB];
  assign yfx_out  = root[RB];
  assign xfx_out  = xq[RB];

endmodule

// ----- sv/tafs_steps.sv -----
// Rounding to millimetres, step conversion dividers and result register.
// Depends on tafs_pkg.
module tafs_steps import tafs_pkg::*; #(
  parameter int LENGTH_BITS = 14,
  parameter int FRAC_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [CFG_BITS-1:0]               step_size,
  input  tafs_ctrl_t                        ctrl_in,
  input  logic [LENGTH_BITS+FRAC_BITS-1:0]  xfx_in,
  input  logic [LENGTH_BITS+FRAC_BITS-1:0]  yfx_in,
  output logic                              done,
  output logic [MM_BITS-1:0]                apex_x_mm,
  output logic [MM_BITS-1:0]                apex_y_mm,
  output logic [STEP_BITS-1:0]              apex_x_steps,
  output logic [STEP_BITS-1:0]              apex_y_steps,
  output logic                              invalid
);

  localparam int F  = FRAC_BITS;
  localparam int RB = LENGTH_BITS + FRAC_BITS;
  localparam int MW = LENGTH_BITS + 1;
  localparam int SW = MW + SCALE_BITS;
  localparam int CW = CFG_BITS;
  localparam int EW = SW + STEP_BITS;
  localparam logic [RB:0] HALF = (RB+1)'(1) << (F - 1);

  tafs_ctrl_t    ctrl_r, ctrl_m;
  logic [RB:0]   xsum, ysum;
  logic [MW-1:0] xm_r, ym_r, xm_m, ym_m;
  logic [SW-1:0] xp_m, yp_m;

  tafs_ctrl_t    ctl [SW+1];
  logic [CW-1:0] xr  [SW+1];
  logic [CW-1:0] yr  [SW+1];
  logic [SW-1:0] xn  [SW+1];
  logic [SW-1:0] yn  [SW+1];
  logic [MW-1:0] xmm [SW+1];
  logic [MW-1:0] ymm [SW+1];

  logic [EW-1:0] xq_ext, yq_ext;
  logic          off;

  // Round to nearest, ties up
  always_comb begin
    xsum = (RB+1)'(xfx_in) + HALF;
    ysum = (RB+1)'(yfx_in) + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_r <= '0;
      ctrl_m <= '0;
    end else begin
      ctrl_r <= ctrl_in;
      ctrl_m <= ctrl_r;
    end
  end

  always_ff @(posedge clk) begin
    xm_r <= xsum[RB:F];
    ym_r <= ysum[RB:F];
    xp_m <= SW'(xm_r) * SW'(STEP_SCALE);
    yp_m <= SW'(ym_r) * SW'(STEP_SCALE);
    xm_m <= xm_r;
    ym_m <= ym_r;
  end

  assign ctl[0] = ctrl_m;
  assign xr[0]  = '0;
  assign yr[0]  = '0;
  assign xn[0]  = xp_m;
  assign yn[0]  = yp_m;
  assign xmm[0] = xm_m;
  assign ymm[0] = ym_m;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [CW:0] xe, ye;
    logic        xgo, ygo;

    // One quotient bit per lane against the step size
    always_comb begin
      xe  = {xr[k], xn[k][SW-1]};
      ye  = {yr[k], yn[k][SW-1]};
      xgo = (xe >= {1'b0, step_size});
      ygo = (ye >= {1'b0, step_size});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else begin
        ctl[k+1] <= ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      xr[k+1]  <= xgo ? CW'(xe - {1'b0, step_size}) : xe[CW-1:0];
      yr[k+1]  <= ygo ? CW'(ye - {1'b0, step_size}) : ye[CW-1:0];
      xn[k+1]  <= {xn[k][SW-2:0], xgo};
      yn[k+1]  <= {yn[k][SW-2:0], ygo};
      xmm[k+1] <= xmm[k];
      ymm[k+1] <= ymm[k];
    end
  end

  // Saturate step counts; zero step size turns conversion off
  always_comb begin
    xq_ext = EW'(xn[SW]);
    yq_ext = EW'(yn[SW]);
    off    = (step_size == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[SW].valid;
    end
  end

  // Result register; a rejected item reads as all zero
  always_ff @(posedge clk) begin
    invalid <= ctl[SW].invalid;
    if (ctl[SW].invalid) begin
      apex_x_mm    <= '0;
      apex_y_mm    <= '0;
      apex_x_steps <= '0;
      apex_y_steps <= '0;
    end else begin
      apex_x_mm <= MM_BITS'({{MM_BITS{1'b0}}, xmm[SW]});
      apex_y_mm <= MM_BITS'({{MM_BITS{1'b0}}, ymm[SW]});
      if (off) begin
        apex_x_steps <= '0;
        apex_y_steps <= '0;
      end else begin
        apex_x_steps <= (xq_ext > EW'(STEPS_MAX)) ? STEPS_MAX : STEP_BITS'(xq_ext);
        apex_y_steps <= (yq_ext > EW'(STEPS_MAX)) ? STEPS_MAX : STEP_BITS'(yq_ext);
      end
    end
  end

endmodule

// ----- sv/tafs_checker.sv -----
// Port-level checks for the triangle apex pipeline, bound to the top level.
// Depends on tafs_pkg and triangle_apex_from_sides.
module tafs_props import tafs_pkg::*; #(
  parameter int LENGTH_BITS = 14,
  parameter int FRAC_BITS   = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [MM_BITS-1:0]    apex_x_mm,
  input logic [MM_BITS-1:0]    apex_y_mm,
  input logic [STEP_BITS-1:0]  apex_x_steps,
  input logic [STEP_BITS-1:0]  apex_y_steps,
  input logic                  invalid
);

  localparam int LAT = 4 * LENGTH_BITS + 3 * FRAC_BITS + 18;

  // Every transfer in shows up as a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted triangle produced no result");

  // No result appears without a transfer in
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LAT !done)
    else $error("result without accepted triangle");

  // Rejected triangles carry all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && invalid) |-> (apex_x_mm == '0 && apex_y_mm == '0 &&
                           apex_x_steps == '0 && apex_y_steps == '0))
    else $error("rejected triangle with nonzero fields");

endmodule

bind triangle_apex_from_sides tafs_props #(
  .LENGTH_BITS (LENGTH_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_tafs_props (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .apex_x_mm    (apex_x_mm),
  .apex_y_mm    (apex_y_mm),
  .apex_x_steps (apex_x_steps),
  .apex_y_steps (apex_y_steps),
  .invalid      (invalid)
);
